FILE: rtl/core/nhp_pkg.sv
// Shared types, constants and helpers for the Netpbm header parser.
package nhp_pkg;

   localparam int COUNT_WIDTH_DEF = 32;
   localparam int NUM_W = 21;
   localparam int DIM_W = 17;
   localparam int NEED_W = 36;
   localparam int PROD_W = 2 * DIM_W;

   localparam logic [NUM_W-1:0] DIM_LIMIT = NUM_W'(100000);
   localparam logic [NUM_W-1:0] MAXVAL_REQ = NUM_W'(255);
   localparam logic [NUM_W-1:0] DEPTH_MAX = NUM_W'(4);
   localparam logic [2:0] RGB_CH = 3'd3;

   // result status codes
   localparam logic [3:0] ST_OK = 4'd0;
   localparam logic [3:0] ST_MAGIC = 4'd1;
   localparam logic [3:0] ST_ASCII = 4'd2;
   localparam logic [3:0] ST_UNSUP = 4'd3;
   localparam logic [3:0] ST_TOKEN = 4'd4;
   localparam logic [3:0] ST_NOT8 = 4'd5;
   localparam logic [3:0] ST_TRUNC = 4'd6;
   localparam logic [3:0] ST_PAMBAD = 4'd7;
   localparam logic [3:0] ST_PAMBIG = 4'd8;

   // format kinds
   localparam logic [1:0] FK_NONE = 2'd0;
   localparam logic [1:0] FK_GRAY = 2'd1;
   localparam logic [1:0] FK_RGB = 2'd2;
   localparam logic [1:0] FK_PAM = 2'd3;

   // accumulator operations
   localparam logic [1:0] ACC_HOLD = 2'd0;
   localparam logic [1:0] ACC_ZERO = 2'd1;
   localparam logic [1:0] ACC_DIGIT = 2'd2;
   localparam logic [1:0] ACC_STEP = 2'd3;

   // field select
   localparam logic [1:0] FS_W = 2'd0;
   localparam logic [1:0] FS_H = 2'd1;
   localparam logic [1:0] FS_D = 2'd2;
   localparam logic [1:0] FS_M = 2'd3;

   localparam logic [7:0] CH_NL = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_SP = 8'h20;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_P = 8'h50;

   localparam logic [47:0] KW_TEXT [5] = '{"WIDTH ", "HEIGHT", "DEPTH ", "MAXVAL", "ENDHDR"};
   localparam logic [2:0] KW_LEN [5] = '{3'd5, 3'd6, 3'd5, 3'd6, 3'd6};

   typedef struct packed {
      logic       take;
      logic       clear;
      logic [1:0] acc_op;
      logic       store_en;
      logic [1:0] store_sel;
      logic       store_zero;
      logic       mark_hdr;
      logic       count;
      logic [1:0] fmt;
      logic       ok;
   } cmd_type;

   typedef struct packed {
      logic acc_big;
      logic next_big;
      logic hold_is_max;
      logic step_is_max;
      logic wh_nz;
      logic pam_fields_bad;
      logic pam_big;
   } stat_type;

   function automatic logic is_ws(input logic [7:0] c);
      return c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_NL;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

endpackage

FILE: rtl/core/nhp_if.sv
// Word channel interfaces for file bytes in and parse results out.
interface nhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_file;
   modport source (output valid, data_byte, end_of_file, input ready);
   modport sink (input valid, data_byte, end_of_file, output ready);
endinterface

interface nhp_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic        data_short;
   logic [16:0] image_width;
   logic [16:0] image_height;
   logic [2:0]  channels;
   logic [31:0] header_length;
   logic [35:0] pixel_bytes;
   modport source (output valid, status, data_short, image_width, image_height, channels,
                   header_length, pixel_bytes, input ready);
   modport sink (input valid, status, data_short, image_width, image_height, channels,
                 header_length, pixel_bytes, output ready);
endinterface

FILE: rtl/core/nhp_datapath.sv
// Datapath: number accumulator, header fields, byte counters, size multiplier.
module nhp_datapath #(
   parameter int COUNT_WIDTH = nhp_pkg::COUNT_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          data_byte,
   input  nhp_pkg::cmd_type    cmd,
   output nhp_pkg::stat_type   stat,
   output logic                data_short,
   output logic [16:0]         image_width,
   output logic [16:0]         image_height,
   output logic [2:0]          channels,
   output logic [31:0]         header_length,
   output logic [35:0]         pixel_bytes
);
   import nhp_pkg::*;

   localparam int CMP_W = (COUNT_WIDTH > NEED_W) ? COUNT_WIDTH : NEED_W;
   localparam int HL_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

   logic [NUM_W-1:0] acc_ff, acc_in, w_ff, w_in, h_ff, h_in, d_ff, d_in, m_ff, m_in;
   logic [COUNT_WIDTH-1:0] bpos_ff, bpos_in, hdr_ff, hdr_in, pay_ff, pay_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [3:0] digit;
   logic [NUM_W+3:0] step_wide;
   logic [NUM_W-1:0] store_val;
   logic [2:0] ch;

   assign digit = 4'(data_byte - CH_ZERO);
   assign step_wide = {4'b0, acc_ff} * (NUM_W+4)'(10) + (NUM_W+4)'(digit);

   always_comb begin
      case (cmd.acc_op)
         ACC_ZERO:  acc_in = '0;
         ACC_DIGIT: acc_in = NUM_W'(digit);
         ACC_STEP:  acc_in = step_wide[NUM_W-1:0];
         default:   acc_in = acc_ff;
      endcase
   end

   assign stat.acc_big = acc_ff > DIM_LIMIT;
   assign stat.next_big = step_wide > (NUM_W+4)'(DIM_LIMIT);
   assign stat.hold_is_max = acc_ff == MAXVAL_REQ;
   assign stat.step_is_max = step_wide == (NUM_W+4)'(MAXVAL_REQ);
   assign stat.wh_nz = (w_ff != '0) && (h_ff != '0);
   assign stat.pam_fields_bad = (w_ff == '0) || (h_ff == '0) || (d_ff == '0) ||
                                (d_ff > DEPTH_MAX) || (m_ff != MAXVAL_REQ);
   assign stat.pam_big = (w_ff > DIM_LIMIT) || (h_ff > DIM_LIMIT);

   assign store_val = cmd.store_zero ? '0 : acc_in;
   assign bpos_in = (bpos_ff == CNT_MAX) ? bpos_ff : bpos_ff + 1'b1;

   always_comb begin
      w_in = w_ff;
      h_in = h_ff;
      d_in = d_ff;
      m_in = m_ff;
      if (cmd.store_en) begin
         case (cmd.store_sel)
            FS_W:    w_in = store_val;
            FS_H:    h_in = store_val;
            FS_D:    d_in = store_val;
            default: m_in = store_val;
         endcase
      end
      hdr_in = cmd.mark_hdr ? bpos_in : hdr_ff;
      pay_in = (cmd.count && pay_ff != CNT_MAX) ? pay_ff + 1'b1 : pay_ff;
   end

   always_comb begin
      case (cmd.fmt)
         FK_GRAY: ch = 3'd1;
         FK_RGB:  ch = RGB_CH;
         default: ch = d_ff[2:0];
      endcase
   end

   assign prod_in = w_ff[DIM_W-1:0] * h_ff[DIM_W-1:0];
   assign need_in = NEED_W'(prod_ff) * NEED_W'(ch);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      need_ff <= need_in;
      if (reset || cmd.clear) begin
         acc_ff <= '0;
         w_ff <= '0;
         h_ff <= '0;
         d_ff <= '0;
         m_ff <= '0;
         bpos_ff <= '0;
         hdr_ff <= '0;
         pay_ff <= '0;
      end else if (cmd.take) begin
         acc_ff <= acc_in;
         w_ff <= w_in;
         h_ff <= h_in;
         d_ff <= d_in;
         m_ff <= m_in;
         bpos_ff <= bpos_in;
         hdr_ff <= hdr_in;
         pay_ff <= pay_in;
      end
   end

   assign data_short = cmd.ok && (CMP_W'(pay_ff) < CMP_W'(need_ff));
   assign image_width = cmd.ok ? w_ff[DIM_W-1:0] : '0;
   assign image_height = cmd.ok ? h_ff[DIM_W-1:0] : '0;
   assign channels = cmd.ok ? ch : '0;
   assign header_length = !cmd.ok ? '0 :
                          (HL_W'(hdr_ff) > HL_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF :
                          32'(hdr_ff);
   assign pixel_bytes = cmd.ok ? need_ff : '0;

endmodule

FILE: rtl/core/nhp_control.sv
// Controller: parse phase machine, keyword matcher, error latch, result sequencing.
module nhp_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [7:0]        data_byte,
   input  logic              end_of_file,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  nhp_pkg::stat_type stat,
   output nhp_pkg::cmd_type  cmd,
   output logic [3:0]        status
);
   import nhp_pkg::*;

   localparam logic [3:0] PH_MAGIC0 = 4'd0;
   localparam logic [3:0] PH_MAGIC1 = 4'd1;
   localparam logic [3:0] PH_SEP = 4'd2;
   localparam logic [3:0] PH_COMMENT = 4'd3;
   localparam logic [3:0] PH_NUM = 4'd4;
   localparam logic [3:0] PH_KEY = 4'd5;
   localparam logic [3:0] PH_PNUM = 4'd6;
   localparam logic [3:0] PH_SKIP = 4'd7;
   localparam logic [3:0] PH_END = 4'd8;
   localparam logic [3:0] PH_PAYLOAD = 4'd9;
   localparam logic [3:0] PH_ERROR = 4'd10;

   localparam logic [1:0] SQ_RUN = 2'd0;
   localparam logic [1:0] SQ_W1 = 2'd1;
   localparam logic [1:0] SQ_W2 = 2'd2;
   localparam logic [1:0] SQ_OUT = 2'd3;

   localparam int KW_W = 0;
   localparam int KW_H = 1;
   localparam int KW_D = 2;
   localparam int KW_M = 3;
   localparam int KW_E = 4;

   localparam int NF_NEG = 0;
   localparam int NF_HAVE = 1;
   localparam int NF_OVF = 2;

   logic [3:0] ph_ff, ph_in, err_ff, err_in, inv_ff, inv_in;
   logic [1:0] fk_ff, fk_in, ti_ff, ti_in, seq_ff, seq_in;
   logic       prev_ff, prev_in;
   logic [2:0] lp_ff, lp_in, nf_ff, nf_in;
   logic [4:0] km_ff, km_in;
   logic       take, done, do_pnm, do_pam, pnm_ok, pam_bad, is_nl;
   logic [7:0] c;

   function automatic logic [3:0] latch_err(input logic [3:0] cur, input logic [3:0] code);
      return (cur == ST_OK) ? code : cur;
   endfunction

   assign c = data_byte;
   assign is_nl = c == CH_NL;
   assign take = req_valid && req_ready;
   assign done = rsp_valid && rsp_ready;
   assign req_ready = seq_ff == SQ_RUN;
   assign rsp_valid = seq_ff == SQ_OUT;
   assign status = err_ff;

   always_comb begin
      ph_in = ph_ff;
      err_in = err_ff;
      inv_in = inv_ff;
      fk_in = fk_ff;
      ti_in = ti_ff;
      lp_in = lp_ff;
      nf_in = nf_ff;
      km_in = km_ff;
      prev_in = is_nl;
      do_pnm = 1'b0;
      do_pam = 1'b0;
      pnm_ok = 1'b0;
      cmd = '0;
      cmd.acc_op = ACC_HOLD;
      pam_bad = inv_ff != 4'd0 || stat.pam_fields_bad;

      case (ph_ff)
         PH_MAGIC0: begin
            if (c != CH_P) begin
               err_in = latch_err(err_in, ST_MAGIC);
               ph_in = PH_ERROR;
            end else begin
               ph_in = PH_MAGIC1;
            end
         end
         PH_MAGIC1: begin
            if (c inside {["1":"4"]}) begin
               err_in = latch_err(err_in, ST_ASCII);
               ph_in = PH_ERROR;
            end else if (c == "5") begin
               fk_in = FK_GRAY;
               ph_in = PH_SEP;
            end else if (c == "6") begin
               fk_in = FK_RGB;
               ph_in = PH_SEP;
            end else if (c == "7") begin
               fk_in = FK_PAM;
               ph_in = PH_KEY;
               lp_in = '0;
               km_in = '1;
            end else begin
               err_in = latch_err(err_in, ST_UNSUP);
               ph_in = PH_ERROR;
            end
         end
         PH_SEP: begin
            if (c == CH_HASH && ti_ff != 2'd0 && prev_ff) begin
               ph_in = PH_COMMENT;
            end else if (is_ws(c)) begin
               ph_in = PH_SEP;
            end else if (is_digit(c)) begin
               cmd.acc_op = ACC_DIGIT;
               ph_in = PH_NUM;
            end else begin
               err_in = latch_err(err_in, ST_TOKEN);
               ph_in = PH_ERROR;
            end
         end
         PH_COMMENT: begin
            if (is_nl) ph_in = PH_SEP;
         end
         PH_NUM: begin
            if (is_digit(c)) begin
               cmd.acc_op = ACC_STEP;
               if (stat.next_big) begin
                  err_in = latch_err(err_in, ST_TOKEN);
                  ph_in = PH_ERROR;
               end
            end else begin
               do_pnm = 1'b1;
               if (ti_ff >= 2'd2) begin
                  if (!(stat.wh_nz && stat.hold_is_max)) begin
                     err_in = latch_err(err_in, ST_NOT8);
                     ph_in = PH_ERROR;
                  end else if (is_ws(c)) begin
                     cmd.mark_hdr = 1'b1;
                     ph_in = PH_PAYLOAD;
                  end else begin
                     err_in = latch_err(err_in, ST_TOKEN);
                     ph_in = PH_ERROR;
                  end
               end else if (is_ws(c)) begin
                  ph_in = PH_SEP;
               end else begin
                  err_in = latch_err(err_in, ST_TOKEN);
                  ph_in = PH_ERROR;
               end
            end
         end
         PH_KEY: begin
            if (is_nl) begin
               ph_in = PH_KEY;
               lp_in = '0;
               km_in = '1;
            end else begin
               if (lp_ff < 3'd6) begin
                  for (int k = 0; k < 5; k++) begin
                     if (km_ff[k] && lp_ff < KW_LEN[k] &&
                         KW_TEXT[k][47 - 8 * lp_ff -: 8] != c)
                        km_in[k] = 1'b0;
                  end
               end
               if (km_in == 5'd0) begin
                  ph_in = PH_SKIP;
               end else if (lp_ff == 3'd5 && km_in[KW_E]) begin
                  ph_in = PH_END;
               end else if ((lp_ff == 3'd6 && (km_in[KW_W] || km_in[KW_D])) ||
                            (lp_ff == 3'd7 && (km_in[KW_H] || km_in[KW_M]))) begin
                  nf_in = '0;
                  cmd.acc_op = ACC_ZERO;
                  if (c == CH_MINUS) begin
                     nf_in[NF_NEG] = 1'b1;
                     ph_in = PH_PNUM;
                  end else if (is_digit(c)) begin
                     cmd.acc_op = ACC_DIGIT;
                     nf_in[NF_HAVE] = 1'b1;
                     ph_in = PH_PNUM;
                  end else begin
                     do_pam = 1'b1;
                     ph_in = PH_SKIP;
                  end
               end else if (lp_ff < 3'd7) begin
                  lp_in = lp_ff + 3'd1;
               end
            end
         end
         PH_PNUM: begin
            if (is_digit(c)) begin
               if (stat.acc_big) begin
                  nf_in[NF_OVF] = 1'b1;
                  do_pam = 1'b1;
                  ph_in = PH_SKIP;
               end else begin
                  cmd.acc_op = ACC_STEP;
                  nf_in[NF_HAVE] = 1'b1;
               end
            end else begin
               do_pam = 1'b1;
               if (is_nl) begin
                  ph_in = PH_KEY;
                  lp_in = '0;
                  km_in = '1;
               end else begin
                  ph_in = PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            if (is_nl) begin
               ph_in = PH_KEY;
               lp_in = '0;
               km_in = '1;
            end
         end
         PH_END: begin
            if (is_nl) begin
               cmd.mark_hdr = 1'b1;
               if (pam_bad) begin
                  err_in = latch_err(err_in, ST_PAMBAD);
                  ph_in = PH_ERROR;
               end else if (stat.pam_big) begin
                  err_in = latch_err(err_in, ST_PAMBIG);
                  ph_in = PH_ERROR;
               end else begin
                  ph_in = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: cmd.count = 1'b1;
         default: ;
      endcase

      if (ph_ff == PH_MAGIC0 && end_of_file) begin
         err_in = latch_err(err_in, ST_MAGIC);
         ph_in = PH_ERROR;
      end

      // end of file: close whatever the header was in the middle of
      if (end_of_file) begin
         case (ph_in)
            PH_SEP, PH_COMMENT: begin
               err_in = latch_err(err_in, ST_NOT8);
            end
            PH_NUM: begin
               do_pnm = 1'b1;
               case (cmd.acc_op)
                  ACC_HOLD: pnm_ok = stat.wh_nz && stat.hold_is_max;
                  ACC_STEP: pnm_ok = stat.wh_nz && stat.step_is_max;
                  default:  pnm_ok = 1'b0;
               endcase
               if (ti_ff >= 2'd2 && pnm_ok) err_in = latch_err(err_in, ST_TRUNC);
               else err_in = latch_err(err_in, ST_NOT8);
            end
            PH_KEY, PH_PNUM, PH_SKIP, PH_MAGIC1: begin
               err_in = latch_err(err_in, ST_TRUNC);
            end
            PH_END: begin
               cmd.mark_hdr = 1'b1;
               if (pam_bad) err_in = latch_err(err_in, ST_PAMBAD);
               else if (stat.pam_big) err_in = latch_err(err_in, ST_PAMBIG);
            end
            default: ;
         endcase
      end

      if (do_pnm) begin
         cmd.store_en = 1'b1;
         cmd.store_sel = (ti_ff == 2'd0) ? FS_W : (ti_ff == 2'd1) ? FS_H : FS_D;
         if (ti_ff < 2'd3) ti_in = ti_ff + 2'd1;
      end

      // the field is picked by the keyword of the current line
      if (do_pam) begin
         cmd.store_zero = !nf_in[NF_HAVE] || nf_in[NF_OVF] || nf_in[NF_NEG];
         cmd.store_en = km_ff[KW_W] || km_ff[KW_H] || km_ff[KW_D] || km_ff[KW_M];
         cmd.store_sel = km_ff[KW_W] ? FS_W : km_ff[KW_H] ? FS_H : km_ff[KW_D] ? FS_D : FS_M;
         if (cmd.store_en) inv_in[cmd.store_sel] = cmd.store_zero;
      end

      case (seq_ff)
         SQ_RUN:  seq_in = (take && end_of_file) ? SQ_W1 : SQ_RUN;
         SQ_W1:   seq_in = SQ_W2;
         SQ_W2:   seq_in = SQ_OUT;
         default: seq_in = done ? SQ_RUN : SQ_OUT;
      endcase

      cmd.take = take;
      cmd.clear = done;
      cmd.fmt = fk_ff;
      cmd.ok = err_ff == ST_OK;
   end

   always_ff @(posedge clock) begin
      if (reset || done) begin
         ph_ff <= PH_MAGIC0;
         err_ff <= ST_OK;
         inv_ff <= '0;
         fk_ff <= FK_NONE;
         ti_ff <= '0;
         lp_ff <= '0;
         nf_ff <= '0;
         km_ff <= '1;
         prev_ff <= 1'b0;
      end else if (take) begin
         ph_ff <= ph_in;
         err_ff <= err_in;
         inv_ff <= inv_in;
         fk_ff <= fk_in;
         ti_ff <= ti_in;
         lp_ff <= lp_in;
         nf_ff <= nf_in;
         km_ff <= km_in;
         prev_ff <= prev_in;
      end
      if (reset) seq_ff <= SQ_RUN;
      else seq_ff <= seq_in;
   end

endmodule

FILE: rtl/core/netpbm_header_parser.sv
// Top level: streaming Netpbm P5/P6/P7 header parser with payload size check.
// Throughput: one file byte per cycle while a file streams in.
// The byte flagged end_of_file is followed by the size multiply in states SQ_W1
// (width*height) and SQ_W2 (*channels); the result word is then held until taken.
// No byte is accepted from end_of_file until the result word is taken.
// Synchronous active-high reset; the parser also returns to reset after each result.
module netpbm_header_parser #(
   parameter int COUNT_WIDTH = nhp_pkg::COUNT_WIDTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   nhp_req_if.sink   req_if,
   nhp_rsp_if.source rsp_if
);
   import nhp_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   nhp_control u_control (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .data_byte   (req_if.data_byte),
      .end_of_file (req_if.end_of_file),
      .req_ready   (req_if.ready),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .stat        (stat),
      .cmd         (cmd),
      .status      (rsp_if.status)
   );

   nhp_datapath #(.COUNT_WIDTH(COUNT_WIDTH)) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .data_byte     (req_if.data_byte),
      .cmd           (cmd),
      .stat          (stat),
      .data_short    (rsp_if.data_short),
      .image_width   (rsp_if.image_width),
      .image_height  (rsp_if.image_height),
      .channels      (rsp_if.channels),
      .header_length (rsp_if.header_length),
      .pixel_bytes   (rsp_if.pixel_bytes)
   );

   a_no_take_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !req_if.ready)
      else $error("byte accepted while result pending");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready) |=> !rsp_if.valid)
      else $error("result repeated");

   a_ok_has_channels: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status == ST_OK) |-> rsp_if.channels != 3'd0)
      else $error("ok result without channels");

endmodule
